/* design/cow_pa_pkg.sv */
// Package with types, codes and defaults for the copy-on-write page allocator.
package cow_pa_pkg;

    localparam int unsigned FreeDepthDef = 16384;
    localparam int unsigned EditSlotsDef = 32;
    localparam logic [31:0] TotalPagesRst = 32'd131072;
    localparam logic [31:0] FirstUserPage = 32'd2;
    localparam logic [31:0] HeaderPage = 32'd0;
    localparam logic [31:0] TempHeaderPage = 32'd1;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_EDIT    = 2'd2,
        OP_FLUSH   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NO_PAGES   = 3'd1,
        ST_BAD_REL    = 3'd2,
        ST_STACK_FULL = 3'd3,
        ST_TABLE_FULL = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_REL,
        S_PEEK,
        S_LRD,
        S_LCMP,
        S_DEC,
        S_WR2,
        S_RDNEW,
        S_RET,
        S_OUT,
        S_FRD,
        S_FCHK,
        S_FEND
    } t_state;

    typedef struct packed {
        t_status     status;
        logic [31:0] zero_page;
        logic        zero_valid;
        logic [31:0] copy_dest;
        logic [31:0] copy_source;
        logic        copy_valid;
        logic [31:0] result_page;
    } t_res;

    localparam t_res ResZero = '{status: ST_OK, zero_page: '0, zero_valid: 1'b0,
                                 copy_dest: '0, copy_source: '0, copy_valid: 1'b0,
                                 result_page: '0};

endpackage

/* design/cow_page_allocator_core.sv */
// Copy-on-write page allocator with free-page stack, bump pointer and edit table.
// A transaction runs through a sequence of states until its last result; any output stall
// holds it. Allocate, edit and flush walk the edit table slot by slot with one shared
// comparator; release and an allocate that finds no pages do not scan it.
// One transaction is in work at a time; the input is ready in the same cycle that the last result is presented.
// Reset is synchronous: the free stack is empty, the bump pointer is 2 and the edit table is clear.
module cow_page_allocator_core
    import cow_pa_pkg::*;
#(
    parameter int unsigned FREE_DEPTH = FreeDepthDef,
    parameter int unsigned EDIT_SLOTS = EditSlotsDef
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [31:0]  i_cfg_wdata,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [31:0]  i_s_tdata,   // page_number
    input  logic [1:0]   i_s_tuser,   // opcode
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // result_page, copy_valid, copy_source, copy_dest, zero_valid, zero_page, status, 3 pad
    output logic [135:0] o_m_tdata,
    output logic         o_m_tlast
);

    localparam int unsigned SW = $clog2(EDIT_SLOTS);
    localparam int unsigned AW = $clog2(FREE_DEPTH);
    localparam int unsigned CW = AW + 1;
    localparam logic [SW-1:0] LastSlot = SW'(EDIT_SLOTS - 1);
    localparam logic [SW:0] AllSlots = (SW + 1)'(EDIT_SLOTS);
    localparam logic [CW-1:0] StackFull = CW'(FREE_DEPTH);

    logic [31:0] r_stack [FREE_DEPTH];
    logic [31:0] r_eold [EDIT_SLOTS];
    logic [31:0] r_enew [EDIT_SLOTS];

    t_state r_state, n_state;
    logic [31:0] r_total;
    logic [CW-1:0] r_free_cnt, n_free_cnt;
    logic [31:0] r_next, n_next;
    logic [EDIT_SLOTS-1:0] r_used, n_used;
    logic [SW:0] r_free_slots, n_free_slots;
    t_op r_op, n_op;
    logic [31:0] r_pg, n_pg;
    logic [31:0] r_key, n_key;
    logic [31:0] r_np, n_np;
    logic r_phase, n_phase;
    logic [SW-1:0] r_idx, n_idx;
    logic r_found, n_found;
    logic [SW-1:0] r_fidx, n_fidx;
    logic r_have1, n_have1, r_have2, n_have2;
    logic [SW-1:0] r_first, n_first, r_second, n_second;
    t_res r_res, n_res;
    t_res r_pend, n_pend;
    t_res r_out, n_out;
    logic r_ovalid, n_ovalid;
    logic r_olast, n_olast;

    logic [31:0] r_stk_q, r_old_q, r_new_q;
    logic [SW-1:0] rd_addr;
    logic st_we;
    logic [AW-1:0] st_waddr;
    logic [31:0] st_wdata;
    logic ed_we;
    logic [SW-1:0] ed_waddr;
    logic [31:0] ed_wold, ed_wnew;

    logic out_free;
    logic [31:0] cmp_b;
    logic cmp_eq;
    logic [31:0] cand;
    logic need2;
    logic qual;

    assign out_free = !r_ovalid || i_m_tready;
    assign cmp_b = (r_state == S_FCHK) ? r_new_q : r_key;
    assign cmp_eq = (r_old_q == cmp_b);
    assign cand = (r_free_cnt != '0) ? r_stk_q : r_next;
    assign need2 = !r_found && (r_np != r_pg);
    assign qual = r_used[r_idx] && !cmp_eq && (r_old_q >= FirstUserPage);
    assign rd_addr = (r_state == S_RDNEW) ? r_fidx : r_idx;

    always_ff @(posedge i_clk) begin
        r_stk_q <= r_stack[AW'(r_free_cnt - CW'(1))];
        if (st_we) begin
            r_stack[st_waddr] <= st_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_old_q <= r_eold[rd_addr];
        r_new_q <= r_enew[rd_addr];
        if (ed_we) begin
            r_eold[ed_waddr] <= ed_wold;
            r_enew[ed_waddr] <= ed_wnew;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_total <= TotalPagesRst;
            r_free_cnt <= '0;
            r_next <= FirstUserPage;
            r_used <= '0;
            r_free_slots <= AllSlots;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_total <= i_cfg_wdata;
            end
            r_free_cnt <= n_free_cnt;
            r_next <= n_next;
            r_used <= n_used;
            r_free_slots <= n_free_slots;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op <= n_op;
        r_pg <= n_pg;
        r_key <= n_key;
        r_np <= n_np;
        r_phase <= n_phase;
        r_idx <= n_idx;
        r_found <= n_found;
        r_fidx <= n_fidx;
        r_have1 <= n_have1;
        r_have2 <= n_have2;
        r_first <= n_first;
        r_second <= n_second;
        r_res <= n_res;
        r_pend <= n_pend;
        r_out <= n_out;
        r_olast <= n_olast;
    end

    always_comb begin
        n_state = r_state;
        n_free_cnt = r_free_cnt;
        n_next = r_next;
        n_used = r_used;
        n_free_slots = r_free_slots;
        n_op = r_op;
        n_pg = r_pg;
        n_key = r_key;
        n_np = r_np;
        n_phase = r_phase;
        n_idx = r_idx;
        n_found = r_found;
        n_fidx = r_fidx;
        n_have1 = r_have1;
        n_have2 = r_have2;
        n_first = r_first;
        n_second = r_second;
        n_res = r_res;
        n_pend = r_pend;
        n_out = r_out;
        n_olast = r_olast;
        n_ovalid = r_ovalid && !i_m_tready;
        st_we = 1'b0;
        st_waddr = AW'(r_free_cnt);
        st_wdata = r_pg;
        ed_we = 1'b0;
        ed_waddr = r_first;
        ed_wold = r_np;
        ed_wnew = r_np;
        o_s_tready = (r_state == S_IDLE);

        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_op = t_op'(i_s_tuser);
                    n_pg = i_s_tdata;
                    n_res = ResZero;
                    n_idx = '0;
                    n_found = 1'b0;
                    n_have1 = 1'b0;
                    n_have2 = 1'b0;
                    unique case (t_op'(i_s_tuser))
                        OP_ALLOC: n_state = S_PEEK;
                        OP_RELEASE: n_state = S_REL;
                        OP_EDIT: begin
                            n_key = i_s_tdata;
                            n_phase = 1'b0;
                            n_state = S_LRD;
                        end
                        default: begin
                            n_pend = ResZero;
                            n_pend.copy_valid = 1'b1;
                            n_pend.copy_source = TempHeaderPage;
                            n_pend.copy_dest = HeaderPage;
                            n_state = S_FRD;
                        end
                    endcase
                end
            end
            S_REL: begin
                if (r_pg < FirstUserPage || r_pg >= r_next) begin
                    n_res.status = ST_BAD_REL;
                end else if (r_free_cnt == StackFull) begin
                    n_res.status = ST_STACK_FULL;
                end else begin
                    st_we = 1'b1;
                    n_free_cnt = r_free_cnt + CW'(1);
                    n_res.zero_valid = 1'b1;
                    n_res.zero_page = r_pg;
                end
                n_state = S_OUT;
            end
            S_PEEK: begin
                if (r_free_cnt == '0 && r_next >= r_total) begin
                    n_res.status = ST_NO_PAGES;
                    n_state = S_OUT;
                end else begin
                    n_np = cand;
                    n_key = cand;
                    n_phase = 1'b1;
                    n_idx = '0;
                    n_found = 1'b0;
                    n_have1 = 1'b0;
                    n_have2 = 1'b0;
                    n_state = S_LRD;
                end
            end
            S_LRD: n_state = S_LCMP;
            S_LCMP: begin
                if (r_used[r_idx]) begin
                    if (cmp_eq && !r_found) begin
                        n_found = 1'b1;
                        n_fidx = r_idx;
                    end
                end else if (!r_have1) begin
                    n_have1 = 1'b1;
                    n_first = r_idx;
                end else if (!r_have2) begin
                    n_have2 = 1'b1;
                    n_second = r_idx;
                end
                n_idx = r_idx + SW'(1);
                n_state = (r_idx == LastSlot) ? S_DEC : S_LRD;
            end
            S_DEC: begin
                n_state = S_OUT;
                if (!r_phase) begin
                    if (r_found) begin
                        n_state = S_RDNEW;
                    end else if (r_pg <= TempHeaderPage) begin
                        if (r_free_slots == '0) begin
                            n_res.status = ST_TABLE_FULL;
                        end else begin
                            ed_we = 1'b1;
                            ed_wold = r_pg;
                            ed_wnew = TempHeaderPage;
                            n_used[r_first] = 1'b1;
                            n_free_slots = r_free_slots - (SW + 1)'(1);
                            n_res.result_page = TempHeaderPage;
                            n_res.copy_valid = 1'b1;
                            n_res.copy_source = r_pg;
                            n_res.copy_dest = TempHeaderPage;
                        end
                    end else begin
                        n_state = S_PEEK;
                    end
                end else if (r_op == OP_ALLOC) begin
                    if (!r_found && r_free_slots == '0) begin
                        n_res.status = ST_TABLE_FULL;
                    end else begin
                        if (r_free_cnt != '0) n_free_cnt = r_free_cnt - CW'(1);
                        else n_next = r_next + 32'd1;
                        ed_we = 1'b1;
                        if (r_found) begin
                            ed_waddr = r_fidx;
                        end else begin
                            n_used[r_first] = 1'b1;
                            n_free_slots = r_free_slots - (SW + 1)'(1);
                        end
                        n_res.result_page = r_np;
                    end
                end else begin
                    if (r_free_slots < (need2 ? (SW + 1)'(2) : (SW + 1)'(1))) begin
                        n_res.status = ST_TABLE_FULL;
                    end else begin
                        if (r_free_cnt != '0) n_free_cnt = r_free_cnt - CW'(1);
                        else n_next = r_next + 32'd1;
                        ed_we = 1'b1;
                        n_used[r_first] = 1'b1;
                        if (need2) begin
                            n_used[r_second] = 1'b1;
                            n_free_slots = r_free_slots - (SW + 1)'(2);
                            n_state = S_WR2;
                        end else if (r_found) begin
                            ed_waddr = r_fidx;
                            n_second = r_first;
                            n_free_slots = r_free_slots - (SW + 1)'(1);
                            n_state = S_WR2;
                        end else begin
                            ed_wold = r_pg;
                            n_free_slots = r_free_slots - (SW + 1)'(1);
                        end
                        n_res.result_page = r_np;
                        n_res.copy_valid = 1'b1;
                        n_res.copy_source = r_pg;
                        n_res.copy_dest = r_np;
                    end
                end
            end
            S_WR2: begin
                ed_we = 1'b1;
                ed_waddr = r_second;
                ed_wold = r_pg;
                n_state = S_OUT;
            end
            S_RDNEW: n_state = S_RET;
            S_RET: begin
                n_res.result_page = r_new_q;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    n_out = r_res;
                    n_olast = 1'b1;
                    n_ovalid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_FRD: n_state = S_FCHK;
            S_FCHK: begin
                if (!qual || out_free) begin
                    if (qual) begin
                        n_out = r_pend;
                        n_olast = 1'b0;
                        n_ovalid = 1'b1;
                        n_pend = ResZero;
                        if (r_old_q >= r_next) begin
                            n_pend.status = ST_BAD_REL;
                        end else if (r_free_cnt == StackFull) begin
                            n_pend.status = ST_STACK_FULL;
                        end else begin
                            st_we = 1'b1;
                            st_wdata = r_old_q;
                            n_free_cnt = r_free_cnt + CW'(1);
                            n_pend.zero_valid = 1'b1;
                            n_pend.zero_page = r_old_q;
                        end
                    end
                    n_idx = r_idx + SW'(1);
                    n_state = (r_idx == LastSlot) ? S_FEND : S_FRD;
                end
            end
            S_FEND: begin
                if (out_free) begin
                    n_out = r_pend;
                    n_olast = 1'b1;
                    n_ovalid = 1'b1;
                    n_used = '0;
                    n_free_slots = AllSlots;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tlast = r_olast;
    assign o_m_tdata = {3'b000, r_out};

    a_slot_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_slots == AllSlots - (SW + 1)'($countones(r_used)))
        else $error("free slot count disagrees with used bits");

    a_stack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_cnt <= StackFull)
        else $error("free stack count beyond depth");

    a_bump_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next >= FirstUserPage)
        else $error("bump pointer below first user page");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input ready right after a transaction");

endmodule
